// File: src/ntcat_pkg.sv
// shared types, widths, register codes and the thermistor resistance table
// for the ntc adc to temperature unit; no dependencies
package ntcat_pkg;

   localparam int MV_W       = 12;
   localparam int OHM_W      = 20;
   localparam int TEMP_W     = 8;
   localparam int PROD_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int ROM_OHM_W  = 21;
   localparam int ROM_SIZE   = 70;
   localparam int ROM_IDX_W  = 7;

   localparam int AVERAGE_DEPTH_DEF = 8;
   localparam int TABLE_ENTRIES_DEF = 70;

   localparam logic [MV_W-1:0]          REF_RESET    = 12'd1700;
   localparam logic [OHM_W-1:0]         PULLUP_RESET = 20'd47000;
   localparam logic signed [TEMP_W-1:0] INVALID_TEMP = 8'sd99;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFERENCE = 2'd0,
      CSR_PULLUP    = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ntcat_unit_sts_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] deg;
      logic [ROM_OHM_W-1:0]     ohms;
   } ntcat_point_type;

   // descending resistance table, first entry at or below the resistance wins
   function automatic ntcat_point_type ntcat_rom(input logic [ROM_IDX_W-1:0] idx);
      ntcat_point_type p;
      case (idx)
         7'd0:    p = '{-8'sd20, 21'd1135000};
         7'd1:    p = '{-8'sd19, 21'd1068000};
         7'd2:    p = '{-8'sd18, 21'd1004000};
         7'd3:    p = '{-8'sd17, 21'd945000};
         7'd4:    p = '{-8'sd16, 21'd889600};
         7'd5:    p = '{-8'sd15, 21'd837800};
         7'd6:    p = '{-8'sd10, 21'd624100};
         7'd7:    p = '{-8'sd5,  21'd469100};
         7'd8:    p = '{-8'sd4,  21'd443500};
         7'd9:    p = '{-8'sd3,  21'd419500};
         7'd10:   p = '{-8'sd2,  21'd396900};
         7'd11:   p = '{-8'sd1,  21'd375600};
         7'd12:   p = '{8'sd0,   21'd355600};
         7'd13:   p = '{8'sd1,   21'd336800};
         7'd14:   p = '{8'sd2,   21'd319100};
         7'd15:   p = '{8'sd3,   21'd302400};
         7'd16:   p = '{8'sd4,   21'd286700};
         7'd17:   p = '{8'sd5,   21'd271800};
         7'd18:   p = '{8'sd6,   21'd257800};
         7'd19:   p = '{8'sd7,   21'd244700};
         7'd20:   p = '{8'sd8,   21'd232200};
         7'd21:   p = '{8'sd9,   21'd220500};
         7'd22:   p = '{8'sd10,  21'd209400};
         7'd23:   p = '{8'sd11,  21'd198900};
         7'd24:   p = '{8'sd12,  21'd189000};
         7'd25:   p = '{8'sd13,  21'd179700};
         7'd26:   p = '{8'sd14,  21'd170900};
         7'd27:   p = '{8'sd15,  21'd162500};
         7'd28:   p = '{8'sd16,  21'd154600};
         7'd29:   p = '{8'sd17,  21'd147200};
         7'd30:   p = '{8'sd18,  21'd140100};
         7'd31:   p = '{8'sd19,  21'd133400};
         7'd32:   p = '{8'sd20,  21'd127000};
         7'd33:   p = '{8'sd21,  21'd121000};
         7'd34:   p = '{8'sd22,  21'd115400};
         7'd35:   p = '{8'sd23,  21'd110000};
         7'd36:   p = '{8'sd24,  21'd104800};
         7'd37:   p = '{8'sd25,  21'd100000};
         7'd38:   p = '{8'sd26,  21'd95400};
         7'd39:   p = '{8'sd27,  21'd91040};
         7'd40:   p = '{8'sd28,  21'd86900};
         7'd41:   p = '{8'sd29,  21'd82970};
         7'd42:   p = '{8'sd30,  21'd79230};
         7'd43:   p = '{8'sd31,  21'd75690};
         7'd44:   p = '{8'sd32,  21'd72320};
         7'd45:   p = '{8'sd33,  21'd69120};
         7'd46:   p = '{8'sd34,  21'd66070};
         7'd47:   p = '{8'sd35,  21'd63180};
         7'd48:   p = '{8'sd36,  21'd60420};
         7'd49:   p = '{8'sd37,  21'd57810};
         7'd50:   p = '{8'sd38,  21'd55310};
         7'd51:   p = '{8'sd39,  21'd52940};
         7'd52:   p = '{8'sd40,  21'd50680};
         7'd53:   p = '{8'sd41,  21'd48530};
         7'd54:   p = '{8'sd42,  21'd46940};
         7'd55:   p = '{8'sd43,  21'd44530};
         7'd56:   p = '{8'sd44,  21'd42670};
         7'd57:   p = '{8'sd45,  21'd40900};
         7'd58:   p = '{8'sd46,  21'd39210};
         7'd59:   p = '{8'sd47,  21'd37600};
         7'd60:   p = '{8'sd48,  21'd36060};
         7'd61:   p = '{8'sd49,  21'd34600};
         7'd62:   p = '{8'sd50,  21'd33190};
         7'd63:   p = '{8'sd55,  21'd27090};
         7'd64:   p = '{8'sd56,  21'd26030};
         7'd65:   p = '{8'sd57,  21'd25010};
         7'd66:   p = '{8'sd58,  21'd24040};
         7'd67:   p = '{8'sd59,  21'd23110};
         7'd68:   p = '{8'sd60,  21'd22220};
         7'd69:   p = '{8'sd99,  21'd0};
         default: p = '{INVALID_TEMP, 21'd0};
      endcase
      return p;
   endfunction

endpackage

// File: src/ntcat_if.sv
// valid/ready channel interfaces for samples, results and register writes
// depends on ntcat_pkg
interface ntcat_req_if import ntcat_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [MV_W-1:0] sample_mv;
   logic            sample_bad;

   modport source (output valid, output sample_mv, output sample_bad, input ready);
   modport sink   (input valid, input sample_mv, input sample_bad, output ready);
endinterface

interface ntcat_rsp_if import ntcat_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_c;
   logic [MV_W-1:0]          average_mv;

   modport source (output valid, output temperature_c, output average_mv, input ready);
   modport sink   (input valid, input temperature_c, input average_mv, output ready);
endinterface

interface ntcat_csr_if import ntcat_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/ntcat_ring.sv
// sample ring memory with fill count and a serial summing pass, one entry per cycle
// depends on ntcat_pkg
module ntcat_ring import ntcat_pkg::*; #(
   parameter int  DEPTH   = AVERAGE_DEPTH_DEF,
   localparam int COUNT_W = $clog2(DEPTH + 1),
   localparam int SUM_W   = MV_W + $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [MV_W-1:0]    wr_sample,
   output ntcat_unit_sts_type sts,
   output logic [SUM_W-1:0]   sum,
   output logic [COUNT_W-1:0] count
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [MV_W-1:0]    ring_mem [DEPTH];
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               run_ff, run_in;
   logic               pend_ff, pend_in;
   logic               done_ff, done_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [MV_W-1:0]    rd_data_ff;
   logic               rd_en;

   always_comb begin
      slot_in = slot_ff;
      seen_in = seen_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      pend_in = 1'b0;
      done_in = 1'b0;
      acc_in  = acc_ff;
      rd_en   = 1'b0;
      if (wr_en) begin
         slot_in = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         if (seen_ff != COUNT_W'(DEPTH)) begin
            seen_in = seen_ff + COUNT_W'(1);
         end
         // summing starts right after the write lands
         run_in = 1'b1;
         idx_in = '0;
         acc_in = '0;
      end else if (run_ff) begin
         if (idx_ff != seen_ff) begin
            rd_en   = 1'b1;
            idx_in  = idx_ff + COUNT_W'(1);
            pend_in = 1'b1;
         end
         if (pend_ff) begin
            acc_in = acc_ff + SUM_W'(rd_data_ff);
         end
         if (idx_ff == seen_ff && !pend_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[slot_ff] <= wr_sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[idx_ff[SLOT_W-1:0]];
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         seen_ff <= '0;
         idx_ff  <= '0;
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         seen_ff <= seen_in;
         idx_ff  <= idx_in;
         run_ff  <= run_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = run_ff;
   assign sts.done = done_ff;
   assign sum      = acc_ff;
   assign count    = seen_ff;

endmodule

// File: src/ntcat_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on ntcat_pkg
module ntcat_mul import ntcat_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [OHM_W-1:0]   mcand,
   input  logic [MV_W-1:0]    mplier,
   output logic [PROD_W-1:0]  product,
   output ntcat_unit_sts_type sts
);

   localparam int CNT_W = $clog2(MV_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MV_W-1:0]    mpl_ff, mpl_in;
   logic [OHM_W-1:0]   mcd_ff, mcd_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mpl_in  = mpl_ff;
      mcd_in  = mcd_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MV_W);
         mpl_in  = mplier;
         mcd_in  = mcand;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                + (mpl_ff[MV_W-1] ? PROD_W'(mcd_ff) : '0);
         mpl_in = {mpl_ff[MV_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      mpl_ff <= mpl_in;
      mcd_ff <= mcd_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product  = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// File: src/ntcat_div.sv
// restoring divider, one quotient bit per cycle, shared by the average and
// the resistance divisions; depends on ntcat_pkg
module ntcat_div import ntcat_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD_W-1:0]  dividend,
   input  logic [MV_W-1:0]    divisor,
   output logic [PROD_W-1:0]  quotient,
   output ntcat_unit_sts_type sts
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [MV_W-1:0]   rem_ff, rem_in;
   logic [MV_W-1:0]   dvs_ff, dvs_in;
   logic [MV_W:0]     rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff, dvd_ff[PROD_W-1]};
   assign fits   = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PROD_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // dividend shifts out the top while quotient bits fill in from below
         rem_in = fits ? MV_W'(rem_sh - {1'b0, dvs_ff}) : MV_W'(rem_sh);
         dvd_in = {dvd_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = dvd_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// File: src/ntc_adc_to_temperature_unit.sv
// Flow: a bad sample is taken while idle and gives no result. A good sample passes
// through the ring sum, the average divide, the multiply, the resistance divide, the
// table walk (one entry per cycle, at most min(TABLE_ENTRIES,70) entries) and the
// output register; an invalid average ends after the first divide. One sample at a
// time; the next sample is taken while a result waits.
// Reset (synchronous) clears control, fill count and slot; ring contents are kept.
module ntc_adc_to_temperature_unit import ntcat_pkg::*; #(
   parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ntcat_req_if.sink    req_chan,
   ntcat_rsp_if.source  rsp_chan,
   ntcat_csr_if.sink    csr_chan
);

   localparam int COUNT_W  = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W    = MV_W + $clog2(AVERAGE_DEPTH);
   localparam int WALK_LEN = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
   localparam int WALK_W   = $clog2(WALK_LEN + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SUM  = 7'b0000010,
      S_AVG  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_RDIV = 7'b0010000,
      S_WALK = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [MV_W-1:0]          ref_ff, ref_in;
   logic [OHM_W-1:0]         pullup_ff, pullup_in;
   logic [MV_W-1:0]          avg_ff, avg_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [PROD_W-1:0]        ohms_ff, ohms_in;
   logic [WALK_W-1:0]        walk_ff, walk_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [MV_W-1:0]          rsp_avg_ff, rsp_avg_in;

   logic                     req_fire;
   logic                     ring_wr;
   logic [SUM_W-1:0]         ring_sum;
   logic [COUNT_W-1:0]       ring_count;
   ntcat_unit_sts_type       ring_sts;
   logic                     div_start;
   logic [PROD_W-1:0]        div_dvd;
   logic [MV_W-1:0]          div_dvs;
   logic [PROD_W-1:0]        div_q;
   ntcat_unit_sts_type       div_sts;
   logic                     mul_start;
   logic [PROD_W-1:0]        mul_prod;
   ntcat_unit_sts_type       mul_sts;
   logic [MV_W-1:0]          q_low;
   ntcat_point_type          rom_pt;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign ring_wr        = req_fire && !req_chan.sample_bad;
   assign csr_chan.ready = 1'b1;

   assign q_low  = div_q[MV_W-1:0];
   assign rom_pt = ntcat_rom(ROM_IDX_W'(walk_ff));

   // divider serves the average first, then the resistance
   assign div_dvd = (state_ff == S_SUM) ? PROD_W'(ring_sum) : mul_prod;
   assign div_dvs = (state_ff == S_SUM) ? MV_W'(ring_count) : ref_ff - avg_ff;

   ntcat_ring #(
      .DEPTH (AVERAGE_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (ring_wr),
      .wr_sample (req_chan.sample_mv),
      .sts       (ring_sts),
      .sum       (ring_sum),
      .count     (ring_count)
   );

   ntcat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_q),
      .sts      (div_sts)
   );

   ntcat_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (pullup_ff),
      .mplier  (q_low),
      .product (mul_prod),
      .sts     (mul_sts)
   );

   always_comb begin
      ref_in    = ref_ff;
      pullup_in = pullup_ff;
      if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_REFERENCE: ref_in    = csr_chan.data[MV_W-1:0];
            CSR_PULLUP:    pullup_in = csr_chan.data[OHM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      temp_in      = temp_ff;
      ohms_in      = ohms_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_avg_in   = rsp_avg_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (ring_wr) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (ring_sts.done) begin
               div_start = 1'b1;
               state_in  = S_AVG;
            end
         end
         S_AVG: begin
            if (div_sts.done) begin
               avg_in = q_low;
               if (q_low == '0 || q_low >= ref_ff) begin
                  temp_in  = INVALID_TEMP;
                  state_in = S_OUT;
               end else begin
                  mul_start = 1'b1;
                  state_in  = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_sts.done) begin
               div_start = 1'b1;
               state_in  = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_sts.done) begin
               ohms_in  = div_q;
               walk_in  = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_ff == WALK_W'(WALK_LEN)) begin
               temp_in  = INVALID_TEMP;
               state_in = S_OUT;
            end else if (ohms_ff >= PROD_W'(rom_pt.ohms)) begin
               temp_in  = rom_pt.deg;
               state_in = S_OUT;
            end else begin
               walk_in = walk_ff + WALK_W'(1);
            end
         end
         S_OUT: begin
            // output register frees up on a transfer
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = temp_ff;
               rsp_avg_in   = avg_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      temp_ff     <= temp_in;
      ohms_ff     <= ohms_in;
      walk_ff     <= walk_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_ff       <= REF_RESET;
         pullup_ff    <= PULLUP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         pullup_ff    <= pullup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.temperature_c = rsp_temp_ff;
   assign rsp_chan.average_mv    = rsp_avg_ff;

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("multiplier started while busy");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_dvs != '0)
      else $error("divider started with zero divisor");

   a_mul_operand: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (q_low != '0 && q_low < ref_ff))
      else $error("resistance path entered with out-of-range average");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> walk_ff <= WALK_W'(WALK_LEN))
      else $error("table walk ran past its end");

endmodule

// File: tb/sv/tb_ntc_adc_to_temperature_unit.sv
// self-checking testbench for ntc_adc_to_temperature_unit: directed and random
// samples checked against a built-in averaging and thermistor table predictor
// depends on ntcat_pkg, the channel interfaces in ntcat_if and the unit itself
module tb_ntc_adc_to_temperature_unit;
   import ntcat_pkg::*;

   localparam int RING_DEPTH    = AVERAGE_DEPTH_DEF;
   localparam int TABLE_LEN     = ROM_SIZE;
   localparam int SETTLE_CYCLES = 250;
   localparam int HOLD_CYCLES   = 1500;
   localparam int GOOD_PER_RUN  = 300;
   localparam int CYCLE_LIMIT   = 3000000;

   // temperature table, descending resistance
   localparam int NTC_DEG [TABLE_LEN] = '{
      -20, -19, -18, -17, -16, -15, -10, -5, -4, -3, -2, -1,
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
      20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37,
      38, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49, 50,
      55, 56, 57, 58, 59, 60, 99};
   localparam int unsigned NTC_OHMS [TABLE_LEN] = '{
      1135000, 1068000, 1004000, 945000, 889600, 837800, 624100, 469100,
      443500, 419500, 396900, 375600, 355600, 336800, 319100, 302400,
      286700, 271800, 257800, 244700, 232200, 220500, 209400, 198900,
      189000, 179700, 170900, 162500, 154600, 147200, 140100, 133400,
      127000, 121000, 115400, 110000, 104800, 100000, 95400, 91040,
      86900, 82970, 79230, 75690, 72320, 69120, 66070, 63180,
      60420, 57810, 55310, 52940, 50680, 48530, 46940, 44530,
      42670, 40900, 39210, 37600, 36060, 34600, 33190, 27090,
      26030, 25010, 24040, 23110, 22220, 0};

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_c;
      logic [MV_W-1:0]          average_mv;
   } reading_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_idx_type           csr;
      logic [CSR_DATA_W-1:0] value;
      logic                  bad;
      logic                  typed;
      reading_type           want;
   } plan_row_type;

   localparam int PLAN_LEN = 25;
   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd4095, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b0, 1'b1, '{INVALID_TEMP, 12'd0}},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd4095, 1'b0, 1'b1, '{INVALID_TEMP, 12'd2047}},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b0, '0},
      // this sample fills the ring with the reference value
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1700, 1'b0, 1'b1, '{INVALID_TEMP, 12'd1700}},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1690, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b1, 1'b0, '0},
      '{ROW_CSR,    CSR_PULLUP,    20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd1,    1'b0, 1'b0, '0},
      '{ROW_CSR,    CSR_REFERENCE, 20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd2048, 1'b0, 1'b0, '0},
      '{ROW_CSR,    CSR_REFERENCE, 20'd4095, 1'b0, 1'b0, '0},
      '{ROW_CSR,    CSR_PULLUP,    20'd1000000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd0,    1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_REFERENCE, 20'd4095, 1'b0, 1'b0, '0}};

   logic clock = 1'b0;
   logic reset;

   ntcat_req_if req_if ();
   ntcat_rsp_if rsp_if ();
   ntcat_csr_if csr_if ();

   ntc_adc_to_temperature_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [MV_W-1:0]  ring_mv [RING_DEPTH];
   int unsigned      ring_fill = 0;
   int unsigned      ring_slot = 0;
   logic [MV_W-1:0]  ref_mv_cfg = REF_RESET;
   logic [OHM_W-1:0] pullup_cfg = PULLUP_RESET;

   reading_type expected_readings [$];
   int       mismatch_count = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       stall_orders = 0;
   int       stall_taken = 0;
   int       stall_left = 0;
   int       cycle_count = 0;

   function automatic logic signed [TEMP_W-1:0] table_temp(longint unsigned ohms);
      for (int i = 0; i < TABLE_LEN; i++)
         if (ohms >= NTC_OHMS[i]) return TEMP_W'(NTC_DEG[i]);
      return INVALID_TEMP;
   endfunction

   function automatic reading_type predict_reading(logic [MV_W-1:0] mv);
      longint unsigned sum;
      longint unsigned ohms;
      logic [MV_W-1:0] avg;
      reading_type     r;
      ring_mv[ring_slot] = mv;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      sum = 0;
      for (int i = 0; i < ring_fill; i++) sum += ring_mv[i];
      avg = MV_W'(sum / ring_fill);
      r.average_mv = avg;
      // invalid average skips the divide, so a zero reference is safe
      if (avg == 0 || avg >= ref_mv_cfg) begin
         r.temperature_c = INVALID_TEMP;
      end else begin
         ohms = (64'(avg) * 64'(pullup_cfg)) / 64'(ref_mv_cfg - avg);
         r.temperature_c = table_temp(ohms);
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0d] MISMATCH %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic offer_sample(logic [MV_W-1:0] mv, logic bad);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sample_mv  <= mv;
      req_if.sample_bad <= bad;
      do @(posedge clock); while (!req_if.ready);
      if (!bad) expected_readings.push_back(predict_reading(mv));
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] word);
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      // a bad sample may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= word;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_REFERENCE) ref_mv_cfg = word[MV_W-1:0];
      else pullup_cfg = word[OHM_W-1:0];
   endtask

   task automatic run_random(int good_target, bit squeeze);
      int good_sent;
      int level;
      int span;
      int pick;
      int v;
      logic bad;
      good_sent = 0;
      span = (ref_mv_cfg + 64 > 4095) ? 4095 : ref_mv_cfg + 64;
      level = $urandom_range(span);
      while (good_sent < good_target) begin
         if (squeeze && good_sent == 40) stall_orders++;
         pick = $urandom_range(99);
         bad = ($urandom_range(99) < 8);
         if (pick < 5) level = $urandom_range(span);
         // mostly a slowly moving level so the average settles across the table
         if (pick < 82) begin
            v = level + int'($urandom_range(32)) - 16;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
         end else if (pick < 92) begin
            v = $urandom_range(4095);
         end else begin
            v = pick[0] ? 4095 : 0;
         end
         offer_sample(MV_W'(v), bad);
         if (!bad) good_sent++;
      end
   endtask

   // result side ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_taken != stall_orders) begin
         stall_taken  <= stall_orders;
         stall_left   <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result temp %0d avg %0d",
                                      rsp_if.temperature_c, rsp_if.average_mv));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_if.temperature_c !== want.temperature_c)
               report_mismatch($sformatf("temperature_c got %0d expected %0d",
                                         rsp_if.temperature_c, want.temperature_c));
            if (rsp_if.average_mv !== want.average_mv)
               report_mismatch($sformatf("average_mv got %0d expected %0d",
                                         rsp_if.average_mv, want.average_mv));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      plan_row_type          row;
      logic [CSR_DATA_W-1:0] ref_word;
      logic [CSR_DATA_W-1:0] pull_word;
      reset = 1'b1;
      req_if.valid      <= 1'b0;
      req_if.sample_mv  <= '0;
      req_if.sample_bad <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_REFERENCE;
      csr_if.data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         row = DIRECTED_PLAN[i];
         if (row.kind == ROW_CSR) begin
            write_reg(row.csr, row.value);
         end else begin
            offer_sample(row.value[MV_W-1:0], row.bad);
            if (!row.bad && row.typed) begin
               void'(expected_readings.pop_back());
               expected_readings.push_back(row.want);
            end
         end
      end

      for (int run = 0; run < 6; run++) begin
         case (run)
            0: begin ref_word = 20'd1700; pull_word = 20'd47000;   end
            1: begin ref_word = 20'd4095; pull_word = 20'd1000000; end
            2: begin ref_word = 20'd3300; pull_word = 20'd10000;   end
            3: begin ref_word = 20'd1;    pull_word = 20'd1;       end
            4: begin ref_word = 20'd2500; pull_word = 20'hFFFFF;   end
            // upper bits of the reference word are not part of the register
            default: begin
               ref_word  = {8'($urandom), 12'($urandom_range(4095, 1))};
               pull_word = 20'($urandom_range(1048575, 1));
            end
         endcase
         write_reg(CSR_REFERENCE, ref_word);
         write_reg(CSR_PULLUP, pull_word);
         if (run < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 48;
         end else if (run < 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_random(GOOD_PER_RUN, run == 0);
      end

      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
